>>> rtl/core/skt_pkg.sv
package skt_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned KEY_W           = 16;
    localparam int unsigned MASK_W          = 16;
    localparam int unsigned ENTRY_COUNT_W   = 7;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_LISTEN = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_REPORT = 2'd3
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] watch;
        logic [MASK_W-1:0] report;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_LOOK,
        ST_CHK,
        ST_SHIFT,
        ST_INS,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/skt_store.sv
module skt_store #(
    parameter int unsigned DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  skt_pkg::t_entry     i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output skt_pkg::t_entry     o_rdata
);

    skt_pkg::t_entry r_mem [DEPTH];
    skt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sorted_key_event_table.sv
// Sorted key/event table.
// Input channel (i_in_valid / o_in_ready) takes one request: clear, listen,
// check or report, with a key and an event mask. Output channel
// (o_out_valid / i_out_ready) returns exactly one result per request.
// Entries sit in one single-port-write, single-port-read RAM in key order.
// A request is worked on alone; o_in_ready is high only while idle.
// Steps per request, with n valid entries and insert place p: a clear
//   goes straight to the result; other requests run a binary search of
//   probe and compare steps, end the search, fetch and check the lower
//   bound, then hand off the result. A listen insert also shifts the
//   (n - p) entries from p upward by one, then writes the new entry.
// For 64 entries the worst case is an insert at the front of 63 entries,
// set by the shift loop (one entry moved per cycle through the RAM read and write ports).
// A finished result sits in an output register; the next request can be
// accepted while it waits, but that request cannot finish until the
// receiver takes the previous result.
// Reset empties the table (count to zero); RAM contents are not cleared,
// only entries below the count are ever read.
module sorted_key_event_table #(
    parameter int unsigned TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_req_type,
    input  logic [skt_pkg::KEY_W-1:0]          i_key,
    input  logic [skt_pkg::MASK_W-1:0]         i_event_mask,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [skt_pkg::MASK_W-1:0]         o_events_hit,
    output logic                               o_found,
    output logic                               o_table_full,
    output logic [skt_pkg::ENTRY_COUNT_W-1:0]  o_entry_count
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    skt_pkg::t_state r_state, n_state;

    skt_pkg::t_req                 r_req, n_req;
    logic [skt_pkg::KEY_W-1:0]     r_key, n_key;
    logic [skt_pkg::MASK_W-1:0]    r_mask, n_mask;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_lo, n_lo;
    logic [CW-1:0]                 r_hi, n_hi;
    logic [AW-1:0]                 r_sh, n_sh;
    logic [skt_pkg::MASK_W-1:0]    r_hit, n_hit;
    logic                          r_found, n_found;
    logic                          r_full, n_full;

    logic                          r_out_valid, n_out_valid;
    logic [skt_pkg::MASK_W-1:0]    r_out_hit, n_out_hit;
    logic                          r_out_found, n_out_found;
    logic                          r_out_full, n_out_full;
    logic [CW-1:0]                 r_out_count, n_out_count;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    skt_pkg::t_entry               mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    skt_pkg::t_entry               mem_rdata;

    logic [CW-1:0]                 mid;
    logic [CW-1:0]                 cnt_m1;
    logic [AW-1:0]                 lo_idx;
    logic                          present;

    skt_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign mid     = CW'(r_lo + ((r_hi - r_lo) >> 1));
    assign cnt_m1  = CW'(r_count - CW'(1));
    assign lo_idx  = r_lo[AW-1:0];
    assign present = (r_lo < r_count) && (mem_rdata.key == r_key);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_key       = r_key;
        n_mask      = r_mask;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_sh        = r_sh;
        n_hit       = r_hit;
        n_found     = r_found;
        n_full      = r_full;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_hit   = r_out_hit;
        n_out_found = r_out_found;
        n_out_full  = r_out_full;
        n_out_count = r_out_count;
        o_in_ready  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = lo_idx;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = lo_idx;

        case (r_state)
            skt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req   = skt_pkg::t_req'(i_req_type);
                    n_key   = i_key;
                    n_mask  = i_event_mask;
                    n_hit   = '0;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_lo    = '0;
                    n_hi    = r_count;
                    if (skt_pkg::t_req'(i_req_type) == skt_pkg::REQ_CLEAR) begin
                        n_count = '0;
                        n_state = skt_pkg::ST_DONE;
                    end else begin
                        n_state = skt_pkg::ST_PROBE;
                    end
                end
            end
            skt_pkg::ST_PROBE: begin
                if (r_lo < r_hi) begin
                    mem_re    = 1'b1;
                    mem_raddr = mid[AW-1:0];
                    n_state   = skt_pkg::ST_CMP;
                end else begin
                    n_state = skt_pkg::ST_LOOK;
                end
            end
            skt_pkg::ST_CMP: begin
                if (mem_rdata.key < r_key) begin
                    n_lo = CW'(mid + CW'(1));
                end else begin
                    n_hi = mid;
                end
                n_state = skt_pkg::ST_PROBE;
            end
            skt_pkg::ST_LOOK: begin
                // lower bound found; fetch it to see whether the key is there
                mem_re  = (r_lo < r_count);
                n_state = skt_pkg::ST_CHK;
            end
            skt_pkg::ST_CHK: begin
                n_found = present;
                n_state = skt_pkg::ST_DONE;
                case (r_req)
                    skt_pkg::REQ_LISTEN: begin
                        if (present) begin
                            mem_we          = 1'b1;
                            mem_wdata.watch = mem_rdata.watch | r_mask;
                        end else if (r_count == CW'(TABLE_DEPTH)) begin
                            n_full = 1'b1;
                        end else if (r_lo < r_count) begin
                            mem_re    = 1'b1;
                            mem_raddr = cnt_m1[AW-1:0];
                            n_sh      = cnt_m1[AW-1:0];
                            n_state   = skt_pkg::ST_SHIFT;
                        end else begin
                            n_state = skt_pkg::ST_INS;
                        end
                    end
                    skt_pkg::REQ_CHECK: begin
                        if (present) begin
                            n_hit = mem_rdata.report & r_mask;
                        end
                    end
                    skt_pkg::REQ_REPORT: begin
                        if (present) begin
                            mem_we           = 1'b1;
                            mem_wdata.report = r_mask;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            skt_pkg::ST_SHIFT: begin
                // read data holds entry r_sh; move it up one and fetch the next lower
                mem_we    = 1'b1;
                mem_waddr = AW'(r_sh + AW'(1));
                mem_wdata = mem_rdata;
                if (r_sh == lo_idx) begin
                    n_state = skt_pkg::ST_INS;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_sh - AW'(1));
                    n_sh      = AW'(r_sh - AW'(1));
                end
            end
            skt_pkg::ST_INS: begin
                mem_we           = 1'b1;
                mem_waddr        = lo_idx;
                mem_wdata.key    = r_key;
                mem_wdata.watch  = r_mask;
                mem_wdata.report = '0;
                n_count          = CW'(r_count + CW'(1));
                n_state          = skt_pkg::ST_DONE;
            end
            skt_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_found = r_found;
                    n_out_full  = r_full;
                    n_out_count = r_count;
                    n_state     = skt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_key       <= n_key;
        r_mask      <= n_mask;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_sh        <= n_sh;
        r_hit       <= n_hit;
        r_found     <= n_found;
        r_full      <= n_full;
        r_out_hit   <= n_out_hit;
        r_out_found <= n_out_found;
        r_out_full  <= n_out_full;
        r_out_count <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_events_hit  = r_out_hit;
    assign o_found       = r_out_found;
    assign o_table_full  = r_out_full;
    assign o_entry_count = skt_pkg::ENTRY_COUNT_W'(r_out_count);

endmodule

>>> tb/sorted_key_event_table_tb.sv
module sorted_key_event_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF;
    localparam int unsigned REQUEST_GOAL = 1000;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [skt_pkg::MASK_W-1:0]        events_hit;
        logic                              found;
        logic                              table_full;
        logic [skt_pkg::ENTRY_COUNT_W-1:0] entry_count;
    } t_table_result;

    // Shadow copy of the sorted table; predicts one result per request.
    class event_table_tracker;
        logic [skt_pkg::KEY_W-1:0]  key_mem[TABLE_DEPTH];
        logic [skt_pkg::MASK_W-1:0] watch_mem[TABLE_DEPTH];
        logic [skt_pkg::MASK_W-1:0] report_mem[TABLE_DEPTH];
        int                         live_entries;
        t_table_result              pending_results[$];
        int unsigned                error_count;

        function new();
            live_entries = 0;
            error_count = 0;
        endfunction

        // first slot whose key is >= k
        function int insert_place(logic [skt_pkg::KEY_W-1:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = live_entries;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (key_mem[mid] < k) lo = mid + 1;
                else hi = mid;
            end
            return lo;
        endfunction

        function void note_request(skt_pkg::t_req req, logic [skt_pkg::KEY_W-1:0] k,
                                   logic [skt_pkg::MASK_W-1:0] m);
            t_table_result r;
            int pos;
            bit present;
            r = '0;
            if (req == skt_pkg::REQ_CLEAR) begin
                live_entries = 0;
            end else begin
                pos = insert_place(k);
                present = (pos < live_entries) && (key_mem[pos] == k);
                r.found = present;
                case (req)
                    skt_pkg::REQ_LISTEN: begin
                        if (present) begin
                            watch_mem[pos] = watch_mem[pos] | m;
                        end else if (live_entries >= TABLE_DEPTH) begin
                            r.table_full = 1'b1;
                        end else begin
                            for (int i = live_entries; i > pos; i--) begin
                                key_mem[i] = key_mem[i-1];
                                watch_mem[i] = watch_mem[i-1];
                                report_mem[i] = report_mem[i-1];
                            end
                            key_mem[pos] = k;
                            watch_mem[pos] = m;
                            report_mem[pos] = '0;
                            live_entries++;
                        end
                    end
                    skt_pkg::REQ_CHECK: begin
                        if (present) r.events_hit = report_mem[pos] & m;
                    end
                    default: begin
                        if (present) report_mem[pos] = m;
                    end
                endcase
            end
            r.entry_count = live_entries[skt_pkg::ENTRY_COUNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %p", $time, got);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("events_hit", 32'(want.events_hit), 32'(got.events_hit));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [1:0]                        i_req_type = '0;
    logic [skt_pkg::KEY_W-1:0]         i_key = '0;
    logic [skt_pkg::MASK_W-1:0]        i_event_mask = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [skt_pkg::MASK_W-1:0]        o_events_hit;
    logic                              o_found;
    logic                              o_table_full;
    logic [skt_pkg::ENTRY_COUNT_W-1:0] o_entry_count;

    event_table_tracker        tracker = new();
    int unsigned               requests_sent = 0;
    int unsigned               cycle_count = 0;
    bit                        steady = 1'b0;
    logic [skt_pkg::KEY_W-1:0] key_pool[$];

    sorted_key_event_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_event_mask  (i_event_mask),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_events_hit  (o_events_hit),
        .o_found       (o_found),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sorted_key_event_table verification failed");
        $finish;
    end

    function int unsigned idle_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure
    initial begin
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = idle_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_result({o_events_hit, o_found, o_table_full, o_entry_count});
        end
    end

    task automatic issue_request(skt_pkg::t_req req, logic [skt_pkg::KEY_W-1:0] k,
                                 logic [skt_pkg::MASK_W-1:0] m);
        int unsigned gap;
        gap = idle_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key <= k;
        i_event_mask <= m;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_request(req, k, m);
        requests_sent++;
    endtask

    function void remember_key(logic [skt_pkg::KEY_W-1:0] k);
        key_pool.push_back(k);
        if (key_pool.size() > 48) void'(key_pool.pop_front());
    endfunction

    function logic [skt_pkg::KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (key_pool.size() > 0 && r < 7) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r == 7) return $urandom_range(0, 1) ? '1 : '0;
        return skt_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function logic [skt_pkg::MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return skt_pkg::MASK_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function skt_pkg::t_req pick_request();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return skt_pkg::REQ_CLEAR;
        if (r < 45) return skt_pkg::REQ_LISTEN;
        if (r < 72) return skt_pkg::REQ_CHECK;
        return skt_pkg::REQ_REPORT;
    endfunction

    task automatic mixed_traffic(int unsigned n);
        skt_pkg::t_req req;
        logic [skt_pkg::KEY_W-1:0] k;
        repeat (n) begin
            req = pick_request();
            k = pick_key();
            if (req == skt_pkg::REQ_CLEAR && $urandom_range(0, 1) == 1) key_pool.delete();
            if (req == skt_pkg::REQ_LISTEN) remember_key(k);
            issue_request(req, k, pick_mask());
        end
    endtask

    // Fill to capacity with distinct keys, then push past it.
    // Ascending order never shifts, descending order shifts every entry.
    task automatic fill_table();
        int unsigned order;
        int unsigned stride;
        int unsigned extra;
        logic [skt_pkg::KEY_W-1:0] start;
        logic [skt_pkg::KEY_W-1:0] k;
        order = $urandom_range(0, 2);
        extra = $urandom_range(3, 10);
        if ($urandom_range(0, 3) != 0) issue_request(skt_pkg::REQ_CLEAR, pick_key(), pick_mask());
        key_pool.delete();
        if (order == 2) begin
            // odd stride mod 2^16 keeps keys distinct
            stride = $urandom_range(0, 16'h7FFF) * 2 + 1;
            start = skt_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
        end else begin
            // whole run stays below 2^16 so the order holds
            stride = $urandom_range(1, 65535 / (TABLE_DEPTH + extra));
            start = skt_pkg::KEY_W'($urandom_range(0, 65535 - (TABLE_DEPTH + extra) * stride));
        end
        for (int i = 0; i < TABLE_DEPTH + extra; i++) begin
            if (order == 1) k = skt_pkg::KEY_W'(start + (TABLE_DEPTH + extra - 1 - i) * stride);
            else k = skt_pkg::KEY_W'(start + i * stride);
            if (i < TABLE_DEPTH) remember_key(k);
            issue_request(skt_pkg::REQ_LISTEN, k, pick_mask());
        end
        mixed_traffic($urandom_range(10, 30));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue_request(skt_pkg::REQ_CHECK, 16'h0000, 16'hFFFF);
        issue_request(skt_pkg::REQ_REPORT, 16'h1234, 16'hFFFF);
        issue_request(skt_pkg::REQ_LISTEN, 16'h8000, 16'h0001);
        issue_request(skt_pkg::REQ_LISTEN, 16'h0000, 16'hFFFF);
        issue_request(skt_pkg::REQ_LISTEN, 16'hFFFF, 16'h8000);
        issue_request(skt_pkg::REQ_LISTEN, 16'h8000, 16'h00F0);
        issue_request(skt_pkg::REQ_REPORT, 16'h8000, 16'hFFFF);
        issue_request(skt_pkg::REQ_CHECK, 16'h8000, 16'h0FF0);
        issue_request(skt_pkg::REQ_CHECK, 16'h0000, 16'hFFFF);
        issue_request(skt_pkg::REQ_REPORT, 16'hFFFF, 16'hAAAA);
        issue_request(skt_pkg::REQ_CHECK, 16'hFFFF, 16'h5555);
        issue_request(skt_pkg::REQ_CHECK, 16'hFFFF, 16'hFFFF);
        issue_request(skt_pkg::REQ_CHECK, 16'h7FFF, 16'hFFFF);
        issue_request(skt_pkg::REQ_LISTEN, 16'h7FFF, 16'h0000);
        issue_request(skt_pkg::REQ_REPORT, 16'h0000, 16'h0000);
        issue_request(skt_pkg::REQ_LISTEN, 16'h0000, 16'h0000);
        issue_request(skt_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);
        issue_request(skt_pkg::REQ_CHECK, 16'h8000, 16'hFFFF);
        issue_request(skt_pkg::REQ_REPORT, 16'h8000, 16'hFFFF);
        issue_request(skt_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
        issue_request(skt_pkg::REQ_LISTEN, 16'h1234, 16'h5678);
        issue_request(skt_pkg::REQ_CHECK, 16'h1234, 16'hFFFF);

        while (requests_sent < REQUEST_GOAL) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) fill_table();
            else mixed_traffic($urandom_range(30, 80));
        end
        steady = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.error_count == 0) begin
            $display("sorted_key_event_table verification clean");
        end else begin
            $display("sorted_key_event_table verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/skt_pkg.sv
rtl/core/skt_store.sv
rtl/core/sorted_key_event_table.sv
tb/sorted_key_event_table_tb.sv
